[rtl/tss_pkg.sv]
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and codes for the three-stacks shared buffer.
// ----------------------------------------------------------------------------
package tss_pkg;

   localparam int OPCODE_W = 1;
   localparam int SELECT_W = 2;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;

   typedef logic [OPCODE_W-1:0]      opcode_type;
   typedef logic [SELECT_W-1:0]      select_type;
   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [STATUS_W-1:0]      status_type;

   localparam opcode_type OP_PUSH = 1'b0;
   localparam opcode_type OP_POP  = 1'b1;

   localparam select_type SEL_LOW  = 2'd0;
   localparam select_type SEL_HIGH = 2'd1;
   localparam select_type SEL_MID  = 2'd2;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

endpackage

[rtl/tss_req_if.sv]
// ----------------------------------------------------------------------------
// tss_req_if
// Request channel: one push or pop transaction per handshake.
// ----------------------------------------------------------------------------
interface tss_req_if;
   import tss_pkg::*;

   logic       valid;
   logic       ready;
   opcode_type opcode;
   select_type stack_select;
   word_type   push_value;

   modport source (output valid, output opcode, output stack_select, output push_value,
                   input ready);
   modport sink (input valid, input opcode, input stack_select, input push_value,
                 output ready);
endinterface

[rtl/tss_rsp_if.sv]
// ----------------------------------------------------------------------------
// tss_rsp_if
// Response channel: popped value and status, one transaction per request.
// ----------------------------------------------------------------------------
interface tss_rsp_if;
   import tss_pkg::*;

   logic       valid;
   logic       ready;
   word_type   pop_value;
   status_type status;

   modport source (output valid, output pop_value, output status, input ready);
   modport sink (input valid, input pop_value, input status, output ready);
endinterface

[rtl/three_stacks_shared_buffer.sv]
// Flow: an accepted push passes S_WRITE then S_DONE, a pop S_POP then S_DONE; a refused push,
// a pop of an empty stack or the unused selector goes straight to S_DONE; a push that slides
// the middle stack first moves it in S_SLIDE (one memory read and one write per cycle).
// Throughput: one transaction at a time; the next is taken the cycle after the result is
// handed to the response register, which may wait on rsp_chan.ready.
// Reset: synchronous; all stacks empty, middle base at DEPTH / 3, memory not cleared.
// ----------------------------------------------------------------------------
// three_stacks_shared_buffer
// Bottom, top and middle stacks in one single-port-read memory; the middle
// stack is slid one slot to make room for a neighbor.
// ----------------------------------------------------------------------------
module three_stacks_shared_buffer #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   tss_req_if.sink   req_chan,
   tss_rsp_if.source rsp_chan
);
   import tss_pkg::*;

   localparam int PTR_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);

   localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_MID   = PTR_W'(DEPTH / 3);
   localparam logic [PTR_W-1:0] PTR_ONE   = PTR_W'(1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SLIDE = 3'd1;
   localparam logic [2:0] S_WRITE = 3'd2;
   localparam logic [2:0] S_POP   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [VALUE_WIDTH-1:0] mem [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [VALUE_WIDTH-1:0] mem_wdata;
   logic                   mem_re;
   logic [ADDR_W-1:0]      mem_raddr;

   logic [2:0]       state_ff, state_in;
   logic [PTR_W-1:0] low_ff, low_in;
   logic [PTR_W-1:0] high_ff, high_in;
   logic [PTR_W-1:0] mid_base_ff, mid_base_in;
   logic [PTR_W-1:0] mid_end_ff, mid_end_in;
   logic             pend_valid_ff, pend_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;

   select_type       sel_ff, sel_in;
   logic [WORD_W-1:0] value_ff, value_in;
   logic             dir_right_ff, dir_right_in;
   logic [PTR_W-1:0] src_ff, src_in;
   logic [PTR_W-1:0] left_ff, left_in;
   logic [PTR_W-1:0] pend_dst_ff, pend_dst_in;
   word_type         res_data_ff, res_data_in;
   status_type       res_status_ff, res_status_in;
   word_type         rsp_data_ff, rsp_data_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic req_fire;

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign req_fire           = req_chan.valid && (state_ff == S_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pop_value = rsp_data_ff;
   assign rsp_chan.status    = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      mid_base_in   = mid_base_ff;
      mid_end_in    = mid_end_ff;
      pend_valid_in = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      sel_in        = sel_ff;
      value_in      = value_ff;
      dir_right_in  = dir_right_ff;
      src_in        = src_ff;
      left_in       = left_ff;
      pend_dst_in   = pend_dst_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = VALUE_WIDTH'({{64{1'b0}}, value_ff});
      mem_re        = 1'b0;
      mem_raddr     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               sel_in        = req_chan.stack_select;
               value_in      = req_chan.push_value;
               res_data_in   = '0;
               res_status_in = STATUS_FULL;
               state_in      = S_DONE;
               if (req_chan.opcode == OP_PUSH) begin
                  case (req_chan.stack_select)
                     SEL_LOW: begin
                        if (low_ff < mid_base_ff) begin
                           state_in = S_WRITE;
                        end else if (mid_end_ff < high_ff) begin
                           dir_right_in = 1'b1;
                           src_in       = mid_end_ff - PTR_ONE;
                           left_in      = mid_end_ff - mid_base_ff;
                           state_in     = S_SLIDE;
                        end
                     end
                     SEL_HIGH, SEL_MID: begin
                        if ((req_chan.stack_select == SEL_HIGH && high_ff > mid_end_ff) ||
                            (req_chan.stack_select == SEL_MID && mid_end_ff < high_ff)) begin
                           state_in = S_WRITE;
                        end else if (mid_base_ff > low_ff) begin
                           dir_right_in = 1'b0;
                           src_in       = mid_base_ff;
                           left_in      = mid_end_ff - mid_base_ff;
                           state_in     = S_SLIDE;
                        end
                     end
                     default: begin
                        res_status_in = STATUS_FULL;
                     end
                  endcase
               end else begin
                  res_status_in = STATUS_EMPTY;
                  case (req_chan.stack_select)
                     SEL_LOW: begin
                        if (low_ff != '0) begin
                           low_in    = low_ff - PTR_ONE;
                           mem_re    = 1'b1;
                           mem_raddr = low_in[ADDR_W-1:0];
                           state_in  = S_POP;
                        end
                     end
                     SEL_HIGH: begin
                        if (high_ff != PTR_DEPTH) begin
                           high_in   = high_ff + PTR_ONE;
                           mem_re    = 1'b1;
                           mem_raddr = high_ff[ADDR_W-1:0];
                           state_in  = S_POP;
                        end
                     end
                     SEL_MID: begin
                        if (mid_end_ff > mid_base_ff) begin
                           mid_end_in = mid_end_ff - PTR_ONE;
                           mem_re     = 1'b1;
                           mem_raddr  = mid_end_in[ADDR_W-1:0];
                           state_in   = S_POP;
                        end
                     end
                     default: begin
                        res_status_in = STATUS_EMPTY;
                     end
                  endcase
               end
            end
         end
         S_SLIDE: begin
            if (pend_valid_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_dst_ff[ADDR_W-1:0];
               mem_wdata = rd_data_ff;
            end
            if (left_ff != '0) begin
               mem_re        = 1'b1;
               mem_raddr     = src_ff[ADDR_W-1:0];
               pend_valid_in = 1'b1;
               pend_dst_in   = dir_right_ff ? src_ff + PTR_ONE : src_ff - PTR_ONE;
               src_in        = dir_right_ff ? src_ff - PTR_ONE : src_ff + PTR_ONE;
               left_in       = left_ff - PTR_ONE;
            end else begin
               mid_base_in = dir_right_ff ? mid_base_ff + PTR_ONE : mid_base_ff - PTR_ONE;
               mid_end_in  = dir_right_ff ? mid_end_ff + PTR_ONE : mid_end_ff - PTR_ONE;
               state_in    = S_WRITE;
            end
         end
         S_WRITE: begin
            mem_we        = 1'b1;
            res_data_in   = '0;
            res_status_in = STATUS_OK;
            state_in      = S_DONE;
            case (sel_ff)
               SEL_LOW: begin
                  mem_waddr = low_ff[ADDR_W-1:0];
                  low_in    = low_ff + PTR_ONE;
               end
               SEL_HIGH: begin
                  high_in   = high_ff - PTR_ONE;
                  mem_waddr = high_in[ADDR_W-1:0];
               end
               default: begin
                  mem_waddr  = mid_end_ff[ADDR_W-1:0];
                  mid_end_in = mid_end_ff + PTR_ONE;
               end
            endcase
         end
         S_POP: begin
            res_data_in   = word_type'({{64{1'b0}}, rd_data_ff});
            res_status_in = STATUS_OK;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         low_ff        <= '0;
         high_ff       <= PTR_DEPTH;
         mid_base_ff   <= PTR_MID;
         mid_end_ff    <= PTR_MID;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         low_ff        <= low_in;
         high_ff       <= high_in;
         mid_base_ff   <= mid_base_in;
         mid_end_ff    <= mid_end_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff        <= sel_in;
      value_ff      <= value_in;
      dir_right_ff  <= dir_right_in;
      src_ff        <= src_in;
      left_ff       <= left_in;
      pend_dst_ff   <= pend_dst_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
